// ----- hw/rtl/cfws_pkg.sv -----
// Package for the circular FIFO with search: request and status codes,
// fixed field widths. No dependencies.
package cfws_pkg;

   localparam int CAP_W   = 5;
   localparam int SLOT_W  = 4;
   localparam int COUNT_W = 5;
   localparam int OP_W    = 2;
   localparam int STAT_W  = 2;
   localparam int APB_DW  = 32;
   localparam int APB_AW  = 3;

   localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
   localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
   localparam logic [OP_W-1:0] OP_SEARCH  = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

endpackage

// ----- hw/rtl/circular_fifo_with_search.sv -----
// Circular FIFO with search: slot memory, pointers, search sequencer, APB register.
// Depends on cfws_pkg.
//
//   channel   handshake              payload
//   request   start && !busy         req_operation, req_value
//   result    rsp_strobe (1 cycle)   rsp_status .. rsp_entry_count
//   config    psel&penable&pwrite    paddr, pwdata (capacity at byte address 0)
//
// Enqueue, rejects, unknown codes, empty search: result in the next cycle.
// Dequeue emptying the queue likewise; else the new head slot is read first.
// Search: one slot read per cycle from the head, up to DEPTH entries or a match.
// Reset is synchronous; the slot memory is not cleared, only held entries are read.
// The receiver cannot stall; busy covers multi-cycle requests.
module circular_fifo_with_search
   import cfws_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [OP_W-1:0]              req_operation,
   input  logic signed [DATA_WIDTH-1:0] req_value,
   output logic                         rsp_strobe,
   output logic [STAT_W-1:0]            rsp_status,
   output logic                         rsp_found,
   output logic [SLOT_W-1:0]            rsp_found_slot,
   output logic signed [DATA_WIDTH-1:0] rsp_front_value,
   output logic signed [DATA_WIDTH-1:0] rsp_rear_value,
   output logic                         rsp_is_empty,
   output logic [COUNT_W-1:0]           rsp_entry_count,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [APB_AW-1:0]            paddr,
   input  logic [APB_DW-1:0]            pwdata,
   output logic [APB_DW-1:0]            prdata,
   output logic                         pready
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int RST_EFF = (DEPTH < 16) ? DEPTH : 16;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DEQ  = 2'd1;
   localparam logic [1:0] S_SRCH = 2'd2;

   logic [DATA_WIDTH-1:0] slot_mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic                  rd_en;
   logic [PTR_W-1:0]      rd_addr;
   logic                  wr_en;
   logic [PTR_W-1:0]      wr_addr;

   logic [1:0]            state_ff, state_in;
   logic [PTR_W-1:0]      head_ff, head_in;
   logic [PTR_W-1:0]      tail_ff, tail_in;
   logic [CNT_W-1:0]      occ_ff, occ_in;
   logic [DATA_WIDTH-1:0] front_ff, front_in;
   logic [DATA_WIDTH-1:0] rear_ff, rear_in;
   logic [DATA_WIDTH-1:0] val_ff, val_in;
   logic [PTR_W-1:0]      ptr_ff, ptr_in;
   logic [CNT_W-1:0]      rem_ff, rem_in;
   logic [CAP_W-1:0]      cap_ff, cap_in;
   logic [CNT_W-1:0]      eff_ff, eff_in;

   logic                  strobe_ff, strobe_in;
   logic [STAT_W-1:0]     status_ff, status_in;
   logic                  found_ff, found_in;
   logic [SLOT_W-1:0]     fslot_ff, fslot_in;
   logic [DATA_WIDTH-1:0] rfront_ff, rfront_in;
   logic [DATA_WIDTH-1:0] rrear_ff, rrear_in;
   logic                  empty_ff, empty_in;
   logic [COUNT_W-1:0]    count_ff, count_in;

   logic                  emit;
   logic [STAT_W-1:0]     st_n;
   logic                  found_n;
   logic [PTR_W-1:0]      slot_n;
   logic                  cfg_wr;

   function automatic logic [CNT_W-1:0] eff_of(input logic [CAP_W-1:0] c);
      if (c == '0) begin
         return CNT_W'(1);
      end else if (int'(c) > DEPTH) begin
         return CNT_W'(DEPTH);
      end
      return CNT_W'(c);
   endfunction

   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                                input logic [CNT_W-1:0] eff);
      if (int'(p) + 1 >= int'(eff)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   assign busy   = (state_ff != S_IDLE);
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && !paddr[2];
   assign prdata = paddr[2] ? '0 : APB_DW'(cap_ff);

   always_comb begin
      state_in = state_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      occ_in   = occ_ff;
      front_in = front_ff;
      rear_in  = rear_ff;
      val_in   = val_ff;
      ptr_in   = ptr_ff;
      rem_in   = rem_ff;
      cap_in   = cap_ff;
      eff_in   = eff_ff;
      rd_en    = 1'b0;
      rd_addr  = ptr_ff;
      wr_en    = 1'b0;
      wr_addr  = tail_ff;
      emit     = 1'b0;
      st_n     = ST_OK;
      found_n  = 1'b0;
      slot_n   = '0;

      if (cfg_wr) begin
         cap_in  = pwdata[CAP_W-1:0];
         eff_in  = eff_of(pwdata[CAP_W-1:0]);
         head_in = '0;
         tail_in = PTR_W'(eff_in - 1'b1);
         occ_in  = '0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_operation)
                  OP_ENQUEUE: begin
                     emit = 1'b1;
                     if (occ_ff >= eff_ff) begin
                        st_n = ST_FULL;
                     end else begin
                        tail_in = advance(tail_ff, eff_ff);
                        wr_en   = 1'b1;
                        wr_addr = tail_in;
                        occ_in  = occ_ff + 1'b1;
                        rear_in = req_value;
                        if (occ_ff == '0) begin
                           front_in = req_value;
                        end
                     end
                  end
                  OP_DEQUEUE: begin
                     if (occ_ff == '0) begin
                        st_n = ST_EMPTY;
                        emit = 1'b1;
                     end else begin
                        head_in = advance(head_ff, eff_ff);
                        occ_in  = occ_ff - 1'b1;
                        if (occ_ff == CNT_W'(1)) begin
                           emit = 1'b1;
                        end else begin
                           rd_en    = 1'b1;
                           rd_addr  = head_in;
                           state_in = S_DEQ;
                        end
                     end
                  end
                  OP_SEARCH: begin
                     if (occ_ff == '0) begin
                        emit = 1'b1;
                     end else begin
                        val_in   = req_value;
                        ptr_in   = head_ff;
                        rem_in   = occ_ff;
                        rd_en    = 1'b1;
                        rd_addr  = head_ff;
                        state_in = S_SRCH;
                     end
                  end
                  default: emit = 1'b1;
               endcase
            end
         end
         S_DEQ: begin
            front_in = rd_data_ff;
            emit     = 1'b1;
            state_in = S_IDLE;
         end
         S_SRCH: begin
            if (rd_data_ff == val_ff) begin
               found_n  = 1'b1;
               slot_n   = ptr_ff;
               emit     = 1'b1;
               state_in = S_IDLE;
            end else if (rem_ff == CNT_W'(1)) begin
               emit     = 1'b1;
               state_in = S_IDLE;
            end else begin
               ptr_in  = advance(ptr_ff, eff_ff);
               rem_in  = rem_ff - 1'b1;
               rd_en   = 1'b1;
               rd_addr = ptr_in;
            end
         end
         default: state_in = S_IDLE;
      endcase

      strobe_in = emit;
      status_in = status_ff;
      found_in  = found_ff;
      fslot_in  = fslot_ff;
      rfront_in = rfront_ff;
      rrear_in  = rrear_ff;
      empty_in  = empty_ff;
      count_in  = count_ff;
      if (emit) begin
         status_in = st_n;
         found_in  = found_n;
         fslot_in  = SLOT_W'(slot_n);
         rfront_in = (occ_in != '0) ? front_in : '0;
         rrear_in  = (occ_in != '0) ? rear_in : '0;
         empty_in  = (occ_in == '0);
         count_in  = COUNT_W'(occ_in);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= req_value;
      end
      if (rd_en) begin
         rd_data_ff <= slot_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         head_ff   <= '0;
         tail_ff   <= PTR_W'(RST_EFF - 1);
         occ_ff    <= '0;
         cap_ff    <= CAP_RESET;
         eff_ff    <= CNT_W'(RST_EFF);
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         occ_ff    <= occ_in;
         cap_ff    <= cap_in;
         eff_ff    <= eff_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      front_ff  <= front_in;
      rear_ff   <= rear_in;
      val_ff    <= val_in;
      ptr_ff    <= ptr_in;
      rem_ff    <= rem_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      fslot_ff  <= fslot_in;
      rfront_ff <= rfront_in;
      rrear_ff  <= rrear_in;
      empty_ff  <= empty_in;
      count_ff  <= count_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = status_ff;
   assign rsp_found       = found_ff;
   assign rsp_found_slot  = fslot_ff;
   assign rsp_front_value = rfront_ff;
   assign rsp_rear_value  = rrear_ff;
   assign rsp_is_empty    = empty_ff;
   assign rsp_entry_count = count_ff;

endmodule

// ----- tb/fifo_search_checker.sv -----
// Checker for the circular FIFO with search: watches the request, result and
// register ports, predicts every result and compares it field by field.
// Depends on cfws_pkg.
module fifo_search_checker
   import cfws_pkg::*;
#(
   parameter int                DEPTH      = 16,
   parameter int                DATA_WIDTH = 32,
   parameter logic [APB_AW-1:0] CAP_ADDR   = '0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  logic [OP_W-1:0]              req_operation,
   input  logic signed [DATA_WIDTH-1:0] req_value,
   input  logic                         rsp_strobe,
   input  logic [STAT_W-1:0]            rsp_status,
   input  logic                         rsp_found,
   input  logic [SLOT_W-1:0]            rsp_found_slot,
   input  logic signed [DATA_WIDTH-1:0] rsp_front_value,
   input  logic signed [DATA_WIDTH-1:0] rsp_rear_value,
   input  logic                         rsp_is_empty,
   input  logic [COUNT_W-1:0]           rsp_entry_count,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [APB_AW-1:0]            paddr,
   input  logic [APB_DW-1:0]            pwdata,
   input  logic [APB_DW-1:0]            prdata,
   input  logic                         pready,
   output int                           fail_count,
   output int                           outstanding
);

   typedef struct {
      logic [STAT_W-1:0]            status;
      logic                         found;
      logic [SLOT_W-1:0]            slot;
      logic signed [DATA_WIDTH-1:0] front;
      logic signed [DATA_WIDTH-1:0] rear;
      logic                         empty;
      logic [COUNT_W-1:0]           count;
   } queue_view_type;

   logic signed [DATA_WIDTH-1:0] ring [DEPTH];
   logic [SLOT_W-1:0]            head_ptr;
   logic [SLOT_W-1:0]            tail_ptr;
   logic [COUNT_W-1:0]           held;
   logic [CAP_W-1:0]             cap_reg;
   queue_view_type               expected_views [$];
   int                           errors;

   function automatic logic [COUNT_W-1:0] active_slots();
      if (cap_reg == 0) return COUNT_W'(1);
      if (cap_reg > DEPTH) return COUNT_W'(DEPTH);
      return cap_reg;
   endfunction

   function automatic logic [SLOT_W-1:0] next_slot(logic [SLOT_W-1:0] p);
      logic [COUNT_W-1:0] n;
      n = COUNT_W'(p) + 1'b1;
      return (n >= active_slots()) ? '0 : n[SLOT_W-1:0];
   endfunction

   function automatic void empty_ring();
      head_ptr = '0;
      tail_ptr = SLOT_W'(active_slots() - 1'b1);
      held     = '0;
   endfunction

   function automatic queue_view_type apply_request(logic [OP_W-1:0] op,
                                                    logic signed [DATA_WIDTH-1:0] val);
      queue_view_type    v;
      logic [SLOT_W-1:0] p;
      v.status = ST_OK;
      v.found  = 1'b0;
      v.slot   = '0;
      case (op)
         OP_ENQUEUE: begin
            if (held >= active_slots()) begin
               v.status = ST_FULL;
            end else begin
               tail_ptr       = next_slot(tail_ptr);
               ring[tail_ptr] = val;
               held           = held + 1'b1;
            end
         end
         OP_DEQUEUE: begin
            if (held == 0) begin
               v.status = ST_EMPTY;
            end else begin
               head_ptr = next_slot(head_ptr);
               held     = held - 1'b1;
            end
         end
         OP_SEARCH: begin
            p = head_ptr;
            for (int k = 0; k < held; k++) begin
               if (!v.found && ring[p] === val) begin
                  v.found = 1'b1;
                  v.slot  = p;
               end
               p = next_slot(p);
            end
         end
         default: ;
      endcase
      v.front = (held != 0) ? ring[head_ptr] : '0;
      v.rear  = (held != 0) ? ring[tail_ptr] : '0;
      v.empty = (held == 0);
      v.count = held;
      return v;
   endfunction

   function automatic void check_field(string name, logic [63:0] exp, logic [63:0] act);
      if (act !== exp) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp, act);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      queue_view_type v;
      if (reset) begin
         cap_reg = CAP_RESET;
         empty_ring();
         expected_views.delete();
         errors = 0;
      end else begin
         if (rsp_strobe) begin
            if (expected_views.size() == 0) begin
               $error("result with no request pending");
               errors++;
            end else begin
               v = expected_views.pop_front();
               check_field("status", 64'(v.status), 64'(rsp_status));
               check_field("found", 64'(v.found), 64'(rsp_found));
               check_field("found_slot", 64'(v.slot), 64'(rsp_found_slot));
               check_field("front_value", 64'(v.front), 64'(rsp_front_value));
               check_field("rear_value", 64'(v.rear), 64'(rsp_rear_value));
               check_field("is_empty", 64'(v.empty), 64'(rsp_is_empty));
               check_field("entry_count", 64'(v.count), 64'(rsp_entry_count));
            end
         end
         if (start && !busy)
            expected_views.insert(expected_views.size(),
                                  apply_request(req_operation, req_value));
         if (psel && penable && pready && paddr == CAP_ADDR) begin
            if (pwrite) begin
               cap_reg = pwdata[CAP_W-1:0];
               empty_ring();
            end else begin
               check_field("capacity", 64'(cap_reg), 64'(prdata));
            end
         end
      end
      fail_count  <= errors;
      outstanding <= expected_views.size();
   end

endmodule

// ----- tb/tb_circular_fifo_with_search.sv -----
// Top of the circular FIFO with search testbench: clock, reset, request and
// register stimulus, watchdog and verdict. Depends on cfws_pkg,
// circular_fifo_with_search and fifo_search_checker.
module tb_circular_fifo_with_search;
   import cfws_pkg::*;

   localparam int                DEPTH      = 16;
   localparam int                DATA_WIDTH = 32;
   localparam logic [APB_AW-1:0] CAP_ADDR   = 3'd0;
   localparam logic [APB_AW-1:0] SPARE_ADDR = 3'd4;
   localparam logic [OP_W-1:0]   OP_UNUSED  = 2'd3;
   localparam int                PHASE_ITEMS = 115;
   localparam int                QUIET_LIMIT = 2000;

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic [OP_W-1:0]              req_operation;
   logic signed [DATA_WIDTH-1:0] req_value;
   logic                         rsp_strobe;
   logic [STAT_W-1:0]            rsp_status;
   logic                         rsp_found;
   logic [SLOT_W-1:0]            rsp_found_slot;
   logic signed [DATA_WIDTH-1:0] rsp_front_value;
   logic signed [DATA_WIDTH-1:0] rsp_rear_value;
   logic                         rsp_is_empty;
   logic [COUNT_W-1:0]           rsp_entry_count;
   logic                         psel;
   logic                         penable;
   logic                         pwrite;
   logic [APB_AW-1:0]            paddr;
   logic [APB_DW-1:0]            pwdata;
   logic [APB_DW-1:0]            prdata;
   logic                         pready;
   int                           fail_count;
   int                           outstanding;

   int                           quiet_cycles;
   int                           items_sent;
   int                           searches_sent;
   int                           settings_used;
   bit                           fill_mode;
   bit                           burst_mode;
   logic signed [DATA_WIDTH-1:0] recent [6];

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   circular_fifo_with_search #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) dut (.*);

   fifo_search_checker #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH), .CAP_ADDR(CAP_ADDR))
      checker_i (.*);

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (psel && penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // returns at the edge that accepted the item
   task automatic send_item(logic [OP_W-1:0] op, logic signed [DATA_WIDTH-1:0] val);
      start         <= 1'b1;
      req_operation <= op;
      req_value     <= val;
      do @(posedge clock); while (busy);
      items_sent++;
      if (op == OP_SEARCH) searches_sent++;
   endtask

   task automatic idle_gap();
      int r;
      int n;
      r = $urandom_range(99);
      if (burst_mode || r < 55) n = 0;
      else if (r < 90) n = $urandom_range(3, 1);
      else n = $urandom_range(40, 8);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic reg_access(logic wr, logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_capacity(logic [CAP_W-1:0] cap);
      drain();
      reg_access(1'b1, CAP_ADDR, {27'($urandom_range(32'h07FF_FFFF)), cap});
      reg_access(1'b0, CAP_ADDR, $urandom);
      settings_used++;
   endtask

   function automatic logic signed [DATA_WIDTH-1:0] pick_value();
      int r;
      int k;
      r = $urandom_range(99);
      k = $urandom_range(5);
      if (r < 55) return recent[k];
      if (r < 65) begin
         case ($urandom_range(3))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 32'sh0000_0000;
            default: return -32'sd1;
         endcase
      end
      recent[k] = $urandom;
      return recent[k];
   endfunction

   function automatic logic [OP_W-1:0] pick_op();
      int r;
      r = $urandom_range(99);
      if (r < 3) return OP_UNUSED;
      if (r < 20) return OP_SEARCH;
      if (r < (fill_mode ? 80 : 45)) return OP_ENQUEUE;
      return OP_DEQUEUE;
   endfunction

   task automatic random_phase(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(24) == 0) fill_mode = !fill_mode;
         if ($urandom_range(19) == 0) burst_mode = !burst_mode;
         send_item(pick_op(), pick_value());
         idle_gap();
      end
   endtask

   initial begin
      logic [CAP_W-1:0] caps [10];
      caps = '{5'd1, 5'd2, 5'd16, 5'd3, 5'd17, 5'd5, 5'd31, 5'd8, 5'd16, 5'd0};
      items_sent    = 0;
      searches_sent = 0;
      settings_used = 1;
      fill_mode     = 1'b1;
      burst_mode    = 1'b0;
      for (int i = 0; i < 6; i++) recent[i] = $urandom;
      reset         <= 1'b1;
      start         <= 1'b0;
      req_operation <= OP_ENQUEUE;
      req_value     <= '0;
      psel          <= 1'b0;
      penable       <= 1'b0;
      pwrite        <= 1'b0;
      paddr         <= CAP_ADDR;
      pwdata        <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset capacity: empty cases, extremes, duplicates, no match
      send_item(OP_DEQUEUE, 32'sd0);
      send_item(OP_SEARCH, 32'sd0);
      send_item(OP_UNUSED, 32'sd0);
      drain();
      reg_access(1'b0, CAP_ADDR, '0);
      send_item(OP_ENQUEUE, 32'sh7FFF_FFFF);
      send_item(OP_ENQUEUE, 32'sh8000_0000);
      send_item(OP_ENQUEUE, 32'sh0000_0000);
      send_item(OP_ENQUEUE, -32'sd1);
      send_item(OP_SEARCH, -32'sd1);
      send_item(OP_SEARCH, 32'sh8000_0000);
      send_item(OP_SEARCH, 32'sd5);
      send_item(OP_UNUSED, 32'sh5A5A_5A5A);
      send_item(OP_ENQUEUE, 32'sh8000_0000);
      send_item(OP_SEARCH, 32'sh8000_0000);
      send_item(OP_DEQUEUE, 32'sd0);
      send_item(OP_DEQUEUE, 32'sd0);
      send_item(OP_SEARCH, 32'sh8000_0000);
      // zero capacity behaves as a single slot
      set_capacity(5'd0);
      send_item(OP_ENQUEUE, 32'sh5555_5555);
      send_item(OP_ENQUEUE, 32'shAAAA_AAAA);
      send_item(OP_SEARCH, 32'sh5555_5555);
      send_item(OP_DEQUEUE, 32'sd0);
      send_item(OP_DEQUEUE, 32'sd0);
      send_item(OP_ENQUEUE, 32'shAAAA_AAAA);

      for (int ph = 0; ph < 10; ph++) begin
         if (ph == 9) caps[ph] = CAP_W'($urandom_range(31));
         set_capacity(caps[ph]);
         // writes to an unmapped register must leave the queue alone
         if (ph == 4) begin
            drain();
            reg_access(1'b1, SPARE_ADDR, $urandom);
         end
         random_phase(PHASE_ITEMS);
      end

      drain();
      repeat (30) @(posedge clock);
      $display("Sent %0d requests (%0d searches) over %0d capacity settings,",
               items_sent, searches_sent, settings_used);
      $display("covering full and empty rejects, pointer wrap and repeated values.");
      if (fail_count == 0 && outstanding == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/cfws_pkg.sv
hw/rtl/circular_fifo_with_search.sv
tb/fifo_search_checker.sv
tb/tb_circular_fifo_with_search.sv
